FILE: design/lfw_pkg.sv
`timescale 1ns / 1ps

package lfw_pkg;

  // Line store sizing
  localparam int unsigned MAX_WIDTH  = 255;
  localparam int unsigned STORE_AW   = 8;
  localparam int unsigned STORE_DEPTH = 2 ** STORE_AW;

  // Output word packing
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_W     = 8 * WORD_BYTES;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned OUT_TDATA_W = 72;

  // Register reset values and fixed bytes
  localparam logic [7:0] FOLD_RESET_WIDTH = 8'd80;
  localparam logic [7:0] NEWLINE_BYTE     = 8'h0A;

  // Configuration register indexes
  localparam logic CFG_FOLD_WIDTH  = 1'b0;
  localparam logic CFG_BREAK_BLANK = 1'b1;

  // Input operation codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] b);
    return (b inside {8'h20, [8'h09:8'h0D]});
  endfunction

endpackage

FILE: design/line_fold_wrapper_top.sv
`timescale 1ns / 1ps

// Line folder for a byte stream.
// Input channel in_*: one transfer per item; in_tuser is the operation
// (0 text byte, 1 end of source), in_tdata the text byte.
// Output channel out_*: words of up to eight bytes, first byte lowest;
// out_tlast marks the last word caused by one input item.
// Config port cfg_*: index 0 is the fold width, index 1 the blank-break mode;
// write only while the block is idle.
// A text byte that needs no break is taken while the block stays idle, so the
// next item is not held back. An item that emits a line (newline, end of
// source, or a forced break) holds in_tready low until its final word is
// registered: the single read port of the line store delivers one byte per
// cycle while the output register is free, full words are handed off as
// they fill, and the newline goes into the final word. A forced break in
// blank mode after the width was lowered first scans the store backward,
// one entry per cycle.
// Reset clears the held line and restores width 80, blank mode off; the
// store needs no clearing pass. A stalled receiver holds the output
// register; emission pauses and in_tready stays low until the item is done.
module line_fold_wrapper_top
  import lfw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] operation
  // Output stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count
  output logic                   out_tlast,  // last_word
  // Configuration writes
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [7:0]             cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  // Config registers
  logic [7:0] fold_width_r;
  logic       break_blank_r;

  // Control state
  state_t     state_r, state_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] held_r, held_nxt;
  logic       seen_r, seen_nxt;
  logic [7:0] slot_r, slot_nxt;
  logic [7:0] cut_r, cut_nxt;
  logic       brk_r, brk_nxt;
  logic [7:0] rd_idx_r, rd_idx_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] scan_idx_r, scan_idx_nxt;
  logic       scan_go_r, scan_go_nxt;
  logic       spend_r, spend_nxt;
  logic [7:0] sidx_r, sidx_nxt;
  logic [3:0] asm_cnt_r, asm_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Payload registers
  logic [7:0]        byte_r, byte_nxt;
  logic [WORD_W-1:0] asm_r, asm_nxt;
  logic [WORD_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [3:0]        out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  // Line store
  logic [7:0]          mem [0:STORE_DEPTH-1];
  logic [7:0]          mem_q;
  logic [STORE_AW-1:0] rd_addr;
  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          wr_data;

  // Helpers
  logic [7:0] w_eff;
  logic       in_xfer;
  logic       out_free;
  logic       move;
  logic [3:0] base;
  logic [3:0] cnt_after;
  logic [7:0] fin_head, fin_held;
  logic       fin_seen;

  assign w_eff     = (fold_width_r == 8'd0) ? 8'd1 : fold_width_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_cnt_r, out_bytes_r};
  assign out_tlast  = out_last_r;

  assign rd_addr = head_r + ((state_r == S_SCAN) ? scan_idx_r : rd_idx_r);

  // Word assembly during emission
  assign move      = (state_r == S_EMIT) && (asm_cnt_r == 4'd8) && out_free;
  assign base      = move ? 4'd0 : asm_cnt_r;
  assign cnt_after = base + {3'd0, pend_r};

  // Held line after a break is retired
  assign fin_head = head_r + cut_r;
  assign fin_held = held_r - cut_r;
  assign fin_seen = seen_r && (slot_r >= cut_r);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    held_nxt      = held_r;
    seen_nxt      = seen_r;
    slot_nxt      = slot_r;
    cut_nxt       = cut_r;
    brk_nxt       = brk_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    scan_idx_nxt  = scan_idx_r;
    scan_go_nxt   = scan_go_r;
    spend_nxt     = 1'b0;
    sidx_nxt      = sidx_r;
    asm_cnt_nxt   = asm_cnt_r;
    asm_nxt       = asm_r;
    byte_nxt      = byte_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bytes_nxt = out_bytes_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = head_r + held_r;
    wr_data       = in_tdata;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rd_idx_nxt = 8'd0;
          if (in_tuser == OP_FLUSH || in_tdata == NEWLINE_BYTE) begin
            // Emit the whole held line; end of source with nothing held is silent
            if (in_tuser == OP_DATA || held_r != 8'd0) begin
              cut_nxt   = held_r;
              brk_nxt   = 1'b0;
              state_nxt = S_EMIT;
            end
          end else if (held_r < w_eff) begin
            // Plain append
            wr_en    = 1'b1;
            held_nxt = held_r + 8'd1;
            if (is_blank(in_tdata)) begin
              seen_nxt = 1'b1;
              slot_nxt = held_r;
            end
          end else begin
            // Forced break, byte appended once the line is out
            brk_nxt  = 1'b1;
            byte_nxt = in_tdata;
            if (break_blank_r && seen_r && slot_r < w_eff) begin
              cut_nxt   = slot_r + 8'd1;
              state_nxt = S_EMIT;
            end else if (break_blank_r && seen_r) begin
              scan_idx_nxt = w_eff - 8'd1;
              scan_go_nxt  = 1'b1;
              state_nxt    = S_SCAN;
            end else begin
              cut_nxt   = w_eff;
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_SCAN: begin
        // Backward search for the last blank within the width
        if (spend_r && is_blank(mem_q)) begin
          cut_nxt   = sidx_r + 8'd1;
          state_nxt = S_EMIT;
        end else if (spend_r && sidx_r == 8'd0) begin
          cut_nxt   = w_eff;
          state_nxt = S_EMIT;
        end else if (scan_go_r) begin
          spend_nxt = 1'b1;
          sidx_nxt  = scan_idx_r;
          if (scan_idx_r == 8'd0) begin
            scan_go_nxt = 1'b0;
          end else begin
            scan_idx_nxt = scan_idx_r - 8'd1;
          end
        end
      end

      S_EMIT: begin
        if (move) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = asm_r;
          out_cnt_nxt   = asm_cnt_r;
          out_last_nxt  = 1'b0;
          asm_nxt       = '0;
        end
        asm_cnt_nxt = cnt_after;
        if (pend_r) begin
          asm_nxt[base[2:0]*8 +: 8] = mem_q;
        end
        if (rd_idx_r < cut_r && cnt_after < 4'd8) begin
          rd_idx_nxt = rd_idx_r + 8'd1;
          pend_nxt   = 1'b1;
        end else if (rd_idx_r == cut_r && !pend_r && base < 4'd8) begin
          asm_nxt[base[2:0]*8 +: 8] = NEWLINE_BYTE;
          asm_cnt_nxt = base + 4'd1;
          state_nxt   = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bytes_nxt = asm_r;
          out_cnt_nxt   = asm_cnt_r;
          out_last_nxt  = 1'b1;
          asm_nxt       = '0;
          asm_cnt_nxt   = 4'd0;
          state_nxt     = S_IDLE;
          if (brk_r) begin
            // Drop the emitted bytes, keep the tail, append the pending byte
            head_nxt = fin_head;
            wr_en    = 1'b1;
            wr_addr  = fin_head + fin_held;
            wr_data  = byte_r;
            held_nxt = fin_held + 8'd1;
            if (is_blank(byte_r)) begin
              seen_nxt = 1'b1;
              slot_nxt = fin_held;
            end else begin
              seen_nxt = fin_seen;
              slot_nxt = fin_seen ? (slot_r - cut_r) : 8'd0;
            end
          end else begin
            held_nxt = 8'd0;
            seen_nxt = 1'b0;
            slot_nxt = 8'd0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fold_width_r  <= FOLD_RESET_WIDTH;
      break_blank_r <= 1'b0;
      head_r        <= 8'd0;
      held_r        <= 8'd0;
      seen_r        <= 1'b0;
      slot_r        <= 8'd0;
      cut_r         <= 8'd0;
      brk_r         <= 1'b0;
      rd_idx_r      <= 8'd0;
      pend_r        <= 1'b0;
      scan_idx_r    <= 8'd0;
      scan_go_r     <= 1'b0;
      spend_r       <= 1'b0;
      sidx_r        <= 8'd0;
      asm_cnt_r     <= 4'd0;
      asm_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      held_r     <= held_nxt;
      seen_r     <= seen_nxt;
      slot_r     <= slot_nxt;
      cut_r      <= cut_nxt;
      brk_r      <= brk_nxt;
      rd_idx_r   <= rd_idx_nxt;
      pend_r     <= pend_nxt;
      scan_idx_r <= scan_idx_nxt;
      scan_go_r  <= scan_go_nxt;
      spend_r    <= spend_nxt;
      sidx_r     <= sidx_nxt;
      asm_cnt_r  <= asm_cnt_nxt;
      asm_r      <= asm_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FOLD_WIDTH:  fold_width_r  <= cfg_wdata;
          CFG_BREAK_BLANK: break_blank_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Assembly word never overfills
  a_asm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    asm_cnt_r <= 4'd8)
    else $error("assembly count above eight");

  // Store reads feeding the word only happen while emitting
  a_pend_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_EMIT)
    else $error("store read pending outside emission");

  // The final word always carries at least the newline
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |-> asm_cnt_r != 4'd0)
    else $error("empty final word");

  // Read index never passes the line length
  a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> rd_idx_r <= cut_r)
    else $error("read index past line end");

  // A byte that overflows the width always starts a break
  a_break_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == OP_DATA && in_tdata != NEWLINE_BYTE && held_r >= w_eff)
      |=> state_r != S_IDLE)
    else $error("forced break not started");

endmodule

FILE: test/tb_line_fold_wrapper_top.sv
`timescale 1ns / 1ps

module tb_line_fold_wrapper_top;
  import lfw_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 200;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } text_item_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        last;
  } fold_word_t;

  // DUT signals, inputs known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'h00;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_addr   = 1'b0;
  logic [7:0]             cfg_wdata  = 8'h00;

  // Stimulus and expectations
  text_item_t text_items[$];
  fold_word_t pending_words[$];
  text_item_t next_item;
  fold_word_t want_word;
  int         send_gap     = 0;
  int         recv_gap     = 0;
  int         recv_hold    = 0;
  bit         tx_calm      = 1'b0;
  bit         rx_calm      = 1'b0;
  bit         stall_req    = 1'b0;
  int         fault_count  = 0;
  int         quiet_cycles = 0;

  // Shadow copy of the folder state and registers
  logic [7:0]  fold_w     = FOLD_RESET_WIDTH;
  bit          blank_mode = 1'b0;
  logic [7:0]  line_buf [0:MAX_WIDTH-1];
  int unsigned held_n     = 0;
  int unsigned blank_slot = 0;
  bit          blank_held = 1'b0;

  line_fold_wrapper_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit blank_byte(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  // Apply one input item to the shadow state and queue the words it emits
  function automatic void fold_predict(input logic op, input logic [7:0] ch);
    logic [7:0]  emitted[$];
    int unsigned w, cut, s, i, k, n;
    fold_word_t  wd;
    w = (fold_w == 8'd0) ? 1 : fold_w;
    if ((op == OP_FLUSH && held_n > 0) || (op == OP_DATA && ch == NEWLINE_BYTE)) begin
      for (i = 0; i < held_n; i++) emitted.push_back(line_buf[i]);
      emitted.push_back(NEWLINE_BYTE);
      held_n     = 0;
      blank_held = 1'b0;
      blank_slot = 0;
    end else if (op == OP_DATA) begin
      // forced break: at most one per byte, window is the first w held bytes
      if (held_n >= w) begin
        cut = w;
        if (blank_mode) begin
          if (held_n == w) begin
            s = blank_held ? blank_slot : w;
          end else begin
            s = w;
            for (i = 0; i < w; i++) if (blank_byte(line_buf[i])) s = i;
          end
          if (s < w) cut = s + 1;
        end
        for (i = 0; i < cut; i++) emitted.push_back(line_buf[i]);
        emitted.push_back(NEWLINE_BYTE);
        for (i = 0; i < held_n - cut; i++) line_buf[i] = line_buf[i + cut];
        held_n     = held_n - cut;
        blank_held = 1'b0;
        blank_slot = 0;
        for (i = 0; i < held_n; i++) begin
          if (blank_byte(line_buf[i])) begin
            blank_held = 1'b1;
            blank_slot = i;
          end
        end
      end
      if (held_n < MAX_WIDTH) begin
        line_buf[held_n] = ch;
        if (blank_byte(ch)) begin
          blank_held = 1'b1;
          blank_slot = held_n;
        end
        held_n++;
      end
    end
    // pack eight bytes per word, first byte lowest
    for (k = 0; k * 8 < emitted.size(); k++) begin
      n = emitted.size() - k * 8;
      if (n > 8) n = 8;
      wd = '0;
      for (i = 0; i < n; i++) wd.bytes[8*i +: 8] = emitted[k*8 + i];
      wd.count = n[3:0];
      wd.last  = ((k + 1) * 8 >= emitted.size());
      pending_words.push_back(wd);
    end
  endfunction

  // Input driver: one item per transfer, random gap after each unless tx_calm is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) fold_predict(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0 || text_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_tvalid <= 1'b0;
        end else begin
          next_item = text_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_item.op;
          in_tdata  <= next_item.ch;
          send_gap  = tx_calm ? 0 : $urandom_range(0, 4);
        end
      end
    end
  end

  // Output monitor and checker; also owns the receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_words.size() == 0) begin
          if (fault_count < 10)
            $display("unexpected word: bytes=%h count=%0d last=%0b",
                     out_tdata[63:0], out_tdata[67:64], out_tlast);
          fault_count++;
        end else begin
          want_word = pending_words.pop_front();
          if (out_tdata[63:0] !== want_word.bytes || out_tdata[67:64] !== want_word.count ||
              out_tlast !== want_word.last) begin
            if (fault_count < 10)
              $display("mismatch: expected bytes=%h count=%0d last=%0b, got bytes=%h count=%0d last=%0b",
                       want_word.bytes, want_word.count, want_word.last,
                       out_tdata[63:0], out_tdata[67:64], out_tlast);
            fault_count++;
          end
        end
        recv_gap = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_req) begin
        recv_hold = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer or config write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL line_fold_wrapper_top");
      $finish;
    end
  end

  task automatic queue_byte(input logic op, input logic [7:0] ch);
    text_items.push_back('{op: op, ch: ch});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(OP_DATA, s[i]);
  endtask

  // Mostly words and blanks, some newlines, some arbitrary bytes and flushes
  task automatic queue_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 52)      queue_byte(OP_DATA, 8'(8'h61 + $urandom_range(0, 25)));
      else if (r < 70) queue_byte(OP_DATA, 8'h20);
      else if (r < 75) queue_byte(OP_DATA, NEWLINE_BYTE);
      else if (r < 81) queue_byte(OP_DATA, 8'($urandom_range(9, 13)));
      else if (r < 97) queue_byte(OP_DATA, 8'($urandom_range(0, 255)));
      else             queue_byte(OP_FLUSH, 8'($urandom_range(0, 255)));
    end
  endtask

  // Wait until every item is taken and every word has come back, then settle
  task automatic drain();
    while (text_items.size() != 0 || in_tvalid || pending_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (addr == CFG_FOLD_WIDTH) fold_w = val;
    else                        blank_mode = val[0];
    @(negedge clk);
  endtask

  initial begin
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes, blank edges, empty lines, flush with nothing held
    queue_byte(OP_DATA, 8'h00);
    queue_byte(OP_DATA, 8'hFF);
    queue_byte(OP_DATA, 8'h20);
    queue_byte(OP_DATA, 8'h09);
    queue_byte(OP_DATA, 8'h0D);
    queue_byte(OP_DATA, 8'h08);
    queue_byte(OP_DATA, 8'h0E);
    queue_byte(OP_DATA, 8'h1F);
    queue_byte(OP_DATA, 8'h21);
    queue_byte(OP_DATA, 8'h7F);
    queue_byte(OP_DATA, NEWLINE_BYTE);
    queue_byte(OP_DATA, NEWLINE_BYTE);
    queue_byte(OP_FLUSH, 8'hFF);
    queue_text("ab cd");
    queue_byte(OP_FLUSH, NEWLINE_BYTE);
    queue_byte(OP_FLUSH, 8'h55);
    drain();

    // Zero width folds every byte onto its own line
    write_reg(CFG_FOLD_WIDTH, 8'd0);
    write_reg(CFG_BREAK_BLANK, 8'd1);
    queue_text("a b\tcd\n");
    queue_byte(OP_FLUSH, 8'h00);
    drain();

    // Width lowered with bytes held, blank mode: scan of the first width bytes
    write_reg(CFG_FOLD_WIDTH, 8'd40);
    queue_text("abcde fghijklmn zab");
    drain();
    write_reg(CFG_FOLD_WIDTH, 8'd10);
    queue_text("xyz");
    queue_random(4);
    queue_byte(OP_FLUSH, 8'h00);
    drain();

    // Width lowered with bytes held, plain mode
    write_reg(CFG_FOLD_WIDTH, 8'd20);
    write_reg(CFG_BREAK_BLANK, 8'd0);
    queue_text("the quick brown fox");
    drain();
    write_reg(CFG_FOLD_WIDTH, 8'd7);
    queue_text("jump\n");
    drain();

    // Widest width setting: one line spread over three words
    write_reg(CFG_FOLD_WIDTH, 8'd255);
    for (int i = 0; i < 20; i++)
      queue_byte(OP_DATA, (i == 10) ? 8'h20 : 8'(8'h61 + i));
    queue_byte(OP_DATA, NEWLINE_BYTE);
    drain();

    // Receiver holds off while narrow lines pile up behind it
    write_reg(CFG_FOLD_WIDTH, 8'd3);
    write_reg(CFG_BREAK_BLANK, 8'd1);
    tx_calm = 1'b1;
    queue_random(30);
    stall_req = 1'b1;
    drain();

    // Random phases over assorted settings
    for (int p = 0; p < 4; p++) begin
      r = $urandom_range(0, 9);
      if (r == 0)      write_reg(CFG_FOLD_WIDTH, 8'd0);
      else if (r == 1) write_reg(CFG_FOLD_WIDTH, 8'($urandom_range(13, 255)));
      else             write_reg(CFG_FOLD_WIDTH, 8'($urandom_range(1, 12)));
      write_reg(CFG_BREAK_BLANK, 8'($urandom_range(0, 1)));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      queue_random(6);
      if ($urandom_range(0, 1) != 0) queue_byte(OP_FLUSH, 8'($urandom_range(0, 255)));
      drain();
    end

    if (fault_count == 0 && pending_words.size() == 0) begin
      $display("PASS line_fold_wrapper_top");
    end else begin
      $display("FAIL line_fold_wrapper_top");
    end
    $finish;
  end

endmodule
